// ----- rtl/core/gfp2ntt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gfp2ntt_pkg
// Shared types and constants for the GF(p^2) NTT butterfly datapath.
// ----------------------------------------------------------------------------
package gfp2ntt_pkg;

    // Width of every field port, independent of the prime size.
    localparam int FIELD_W = 61;

    // Butterfly operation codes.
    localparam logic OP_FWD = 1'b0;
    localparam logic OP_BWD = 1'b1;

    // One field element as it appears on the ports.
    typedef logic [FIELD_W-1:0] t_field;

    // Stage enables for the pipelined modular multiplier.
    typedef struct packed {
        logic pp;
        logic sum;
        logic fold;
    } t_mul_en;

endpackage
`default_nettype wire

// ----- rtl/core/gfp2ntt_mmul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gfp2ntt_mmul
// Three-stage modular multiplier for the Mersenne prime 2^PRIME_BITS - 1:
// partial products, product assembly, then fold and one conditional subtract.
// ----------------------------------------------------------------------------
module gfp2ntt_mmul #(
    parameter int PRIME_BITS = 61
) (
    input  wire logic                   i_clk,
    input  wire gfp2ntt_pkg::t_mul_en   i_en,
    input  wire logic [PRIME_BITS-1:0]  i_a,
    input  wire logic [PRIME_BITS-1:0]  i_b,
    output logic      [PRIME_BITS-1:0]  o_p
);

    localparam int PB     = PRIME_BITS;
    localparam int LO_W   = (PB + 1) / 2;
    localparam int HI_W   = PB - LO_W;
    localparam int PROD_W = 2 * PB;
    localparam logic [PB-1:0] P = {PB{1'b1}};

    logic [2*LO_W-1:0] r_ll, n_ll;
    logic [PB-1:0]     r_lh, n_lh;
    logic [PB-1:0]     r_hl, n_hl;
    logic [2*HI_W-1:0] r_hh, n_hh;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [PB-1:0]     r_p, n_p;
    logic [PB:0]       fold_sum;

    // Four half-width partial products.
    always_comb begin
        n_ll = (2*LO_W)'(i_a[LO_W-1:0]) * (2*LO_W)'(i_b[LO_W-1:0]);
        n_lh = PB'(i_a[LO_W-1:0]) * PB'(i_b[PB-1:LO_W]);
        n_hl = PB'(i_a[PB-1:LO_W]) * PB'(i_b[LO_W-1:0]);
        n_hh = (2*HI_W)'(i_a[PB-1:LO_W]) * (2*HI_W)'(i_b[PB-1:LO_W]);
    end

    // Assemble the full double-width product.
    always_comb begin
        n_prod = PROD_W'(r_ll)
               + (PROD_W'(r_lh) << LO_W)
               + (PROD_W'(r_hl) << LO_W)
               + (PROD_W'(r_hh) << (2*LO_W));
    end

    // Fold the upper half onto the lower half, then one conditional subtract.
    always_comb begin
        fold_sum = {1'b0, r_prod[PB-1:0]} + {1'b0, r_prod[PROD_W-1:PB]};
        n_p = (fold_sum >= {1'b0, P}) ? PB'(fold_sum - {1'b0, P}) : fold_sum[PB-1:0];
    end

    // Stage registers, each advanced by its own enable.
    always_ff @(posedge i_clk) begin
        if (i_en.pp) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            r_hh <= n_hh;
        end
        if (i_en.sum) begin
            r_prod <= n_prod;
        end
        if (i_en.fold) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ----- rtl/core/gf_p2_ntt_butterfly.sv -----
`default_nettype none
// An item passes through stage registers 0 to 6 in order from input transfer to result.
// Throughput: one butterfly per cycle while the output is not stalled; every stage holds its own valid bit and
// moves when the stage ahead of it is empty or moving, so bubbles are squeezed out.
// The four modular products take three of the seven stages.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// gf_p2_ntt_butterfly
// Radix-2 NTT butterfly over GF(p^2) with p = 2^PRIME_BITS - 1: forward
// decimation-in-frequency or backward decimation-in-time, chosen per item.
// ----------------------------------------------------------------------------
module gf_p2_ntt_butterfly #(
    parameter int PRIME_BITS = 61
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_opcode,
    input  wire gfp2ntt_pkg::t_field  i_a_re,
    input  wire gfp2ntt_pkg::t_field  i_a_im,
    input  wire gfp2ntt_pkg::t_field  i_b_re,
    input  wire gfp2ntt_pkg::t_field  i_b_im,
    input  wire gfp2ntt_pkg::t_field  i_tw_re,
    input  wire gfp2ntt_pkg::t_field  i_tw_im,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output gfp2ntt_pkg::t_field       o_sum_re,
    output gfp2ntt_pkg::t_field       o_sum_im,
    output gfp2ntt_pkg::t_field       o_diff_re,
    output gfp2ntt_pkg::t_field       o_diff_im
);

    localparam int FIELD_W = gfp2ntt_pkg::FIELD_W;
    localparam int PB      = PRIME_BITS;
    localparam int N_STG   = 7;
    localparam logic [PB-1:0] P = {PB{1'b1}};
    localparam gfp2ntt_pkg::t_field P_FIELD = gfp2ntt_pkg::t_field'(P);

    // Reduce any port value into [0, p).
    function automatic logic [PB-1:0] f_canon(input gfp2ntt_pkg::t_field x);
        logic [FIELD_W:0] t;
        t = {1'b0, x & P_FIELD} + {1'b0, x >> PB};
        f_canon = (t >= {1'b0, P_FIELD}) ? PB'(t - {1'b0, P_FIELD}) : t[PB-1:0];
    endfunction

    // Modular add of two reduced values.
    function automatic logic [PB-1:0] f_madd(input logic [PB-1:0] a, input logic [PB-1:0] b);
        logic [PB:0] t;
        t = {1'b0, a} + {1'b0, b};
        f_madd = (t >= {1'b0, P}) ? PB'(t - {1'b0, P}) : t[PB-1:0];
    endfunction

    // Modular subtract of two reduced values.
    function automatic logic [PB-1:0] f_msub(input logic [PB-1:0] a, input logic [PB-1:0] b);
        logic [PB:0] t;
        t = {1'b0, a} - {1'b0, b};
        f_msub = t[PB] ? (t[PB-1:0] + P) : t[PB-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when it is empty or its
    // contents move on in the same cycle.
    // ------------------------------------------------------------------
    logic [N_STG-1:0] r_v;
    logic [N_STG-1:0] n_v;
    logic [N_STG-1:0] en;

    always_comb begin
        en[N_STG-1] = !r_v[N_STG-1] || i_out_ready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        n_v = {r_v[N_STG-2:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < N_STG; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_v[N_STG-1];

    // ------------------------------------------------------------------
    // Stage 0: reduce the incoming operands.
    // ------------------------------------------------------------------
    logic          r0_op;
    logic [PB-1:0] r0_ar, r0_ai, r0_br, r0_bi, r0_wr, r0_wi;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_op <= i_opcode;
            r0_ar <= f_canon(i_a_re);
            r0_ai <= f_canon(i_a_im);
            r0_br <= f_canon(i_b_re);
            r0_bi <= f_canon(i_b_im);
            r0_wr <= f_canon(i_tw_re);
            r0_wi <= f_canon(i_tw_im);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick the multiplier operand (a - b forward, b backward)
    // and the carried term (a + b forward, a backward).
    // ------------------------------------------------------------------
    logic          r1_op;
    logic [PB-1:0] r1_cr, r1_ci, r1_xr, r1_xi, r1_wr, r1_wi;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_op <= r0_op;
            r1_wr <= r0_wr;
            r1_wi <= r0_wi;
            if (r0_op == gfp2ntt_pkg::OP_FWD) begin
                r1_xr <= f_msub(r0_ar, r0_br);
                r1_xi <= f_msub(r0_ai, r0_bi);
                r1_cr <= f_madd(r0_ar, r0_br);
                r1_ci <= f_madd(r0_ai, r0_bi);
            end else begin
                r1_xr <= r0_br;
                r1_xi <= r0_bi;
                r1_cr <= r0_ar;
                r1_ci <= r0_ai;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 to 4: the four modular products x*w.
    // ------------------------------------------------------------------
    gfp2ntt_pkg::t_mul_en mul_en;
    logic [PB-1:0] m_rr, m_ii, m_ir, m_ri;

    assign mul_en = '{pp: en[2], sum: en[3], fold: en[4]};

    gfp2ntt_mmul #(.PRIME_BITS(PB)) u_mul_rr (
        .i_clk(i_clk), .i_en(mul_en), .i_a(r1_xr), .i_b(r1_wr), .o_p(m_rr)
    );
    gfp2ntt_mmul #(.PRIME_BITS(PB)) u_mul_ii (
        .i_clk(i_clk), .i_en(mul_en), .i_a(r1_xi), .i_b(r1_wi), .o_p(m_ii)
    );
    gfp2ntt_mmul #(.PRIME_BITS(PB)) u_mul_ir (
        .i_clk(i_clk), .i_en(mul_en), .i_a(r1_xi), .i_b(r1_wr), .o_p(m_ir)
    );
    gfp2ntt_mmul #(.PRIME_BITS(PB)) u_mul_ri (
        .i_clk(i_clk), .i_en(mul_en), .i_a(r1_xr), .i_b(r1_wi), .o_p(m_ri)
    );

    // Opcode and carried term ride alongside the multipliers.
    logic          r2_op, r3_op, r4_op;
    logic [PB-1:0] r2_cr, r2_ci, r3_cr, r3_ci, r4_cr, r4_ci;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_op <= r1_op;
            r2_cr <= r1_cr;
            r2_ci <= r1_ci;
        end
        if (en[3]) begin
            r3_op <= r2_op;
            r3_cr <= r2_cr;
            r3_ci <= r2_ci;
        end
        if (en[4]) begin
            r4_op <= r3_op;
            r4_cr <= r3_cr;
            r4_ci <= r3_ci;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: complex product; backward uses the conjugate twiddle.
    // ------------------------------------------------------------------
    logic          r5_op;
    logic [PB-1:0] r5_cr, r5_ci, r5_er, r5_ei;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_op <= r4_op;
            r5_cr <= r4_cr;
            r5_ci <= r4_ci;
            if (r4_op == gfp2ntt_pkg::OP_FWD) begin
                r5_er <= f_msub(m_rr, m_ii);
                r5_ei <= f_madd(m_ir, m_ri);
            end else begin
                r5_er <= f_madd(m_rr, m_ii);
                r5_ei <= f_msub(m_ir, m_ri);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: output register; backward forms a + t and a - t here.
    // ------------------------------------------------------------------
    logic [PB-1:0] r6_sr, r6_si, r6_dr, r6_di;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            if (r5_op == gfp2ntt_pkg::OP_BWD) begin
                r6_sr <= f_madd(r5_cr, r5_er);
                r6_si <= f_madd(r5_ci, r5_ei);
                r6_dr <= f_msub(r5_cr, r5_er);
                r6_di <= f_msub(r5_ci, r5_ei);
            end else begin
                r6_sr <= r5_cr;
                r6_si <= r5_ci;
                r6_dr <= r5_er;
                r6_di <= r5_ei;
            end
        end
    end

    assign o_sum_re  = gfp2ntt_pkg::t_field'(r6_sr);
    assign o_sum_im  = gfp2ntt_pkg::t_field'(r6_si);
    assign o_diff_re = gfp2ntt_pkg::t_field'(r6_dr);
    assign o_diff_im = gfp2ntt_pkg::t_field'(r6_di);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every delivered result is fully reduced.
    a_out_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r6_sr < P) && (r6_si < P) && (r6_dr < P) && (r6_di < P))
        else $error("butterfly result not reduced below p");

    // A full pipeline with a stalled output takes no new item.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while pipeline full and stalled");

    // An item waiting in front of the output register is not dropped.
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[N_STG-2] && !en[N_STG-1]) |=> r_v[N_STG-2])
        else $error("stalled stage lost its item");

endmodule
`default_nettype wire

// ----- dv/gf_p2_ntt_butterfly_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf_p2_ntt_butterfly_checker
// Watches both channels of the GF(p^2) butterfly, predicts each result from
// the accepted operands and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module gf_p2_ntt_butterfly_checker #(
    parameter int PRIME_BITS = 61
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic                 i_opcode,
    input  wire gfp2ntt_pkg::t_field  i_a_re,
    input  wire gfp2ntt_pkg::t_field  i_a_im,
    input  wire gfp2ntt_pkg::t_field  i_b_re,
    input  wire gfp2ntt_pkg::t_field  i_b_im,
    input  wire gfp2ntt_pkg::t_field  i_tw_re,
    input  wire gfp2ntt_pkg::t_field  i_tw_im,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire gfp2ntt_pkg::t_field  i_sum_re,
    input  wire gfp2ntt_pkg::t_field  i_sum_im,
    input  wire gfp2ntt_pkg::t_field  i_diff_re,
    input  wire gfp2ntt_pkg::t_field  i_diff_im,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    // Arithmetic is carried in 64-bit words; results are cut to the port width.
    typedef logic [63:0] t_word;

    typedef struct packed {
        gfp2ntt_pkg::t_field sum_re;
        gfp2ntt_pkg::t_field sum_im;
        gfp2ntt_pkg::t_field diff_re;
        gfp2ntt_pkg::t_field diff_im;
    } t_butterfly_res;

    localparam t_word MODULUS    = (t_word'(1) << PRIME_BITS) - 1;
    localparam t_word FIELD_MASK = (t_word'(1) << gfp2ntt_pkg::FIELD_W) - 1;

    t_butterfly_res butterfly_q[$];
    int             mismatches   = 0;
    int             results_seen = 0;

    // One fold and one conditional subtract bring any port value below p.
    function automatic t_word reduce_operand(gfp2ntt_pkg::t_field x);
        t_word w;
        t_word t;
        w = t_word'(x) & FIELD_MASK;
        t = (w & MODULUS) + (w >> PRIME_BITS);
        return (t >= MODULUS) ? t - MODULUS : t;
    endfunction

    function automatic t_word add_mod(t_word a, t_word b);
        t_word t;
        t = a + b;
        return (t >= MODULUS) ? t - MODULUS : t;
    endfunction

    function automatic t_word sub_mod(t_word a, t_word b);
        t_word t;
        t = a - b;
        return (a < b) ? t + MODULUS : t;
    endfunction

    // Full product, then the bits above p are folded onto the low bits.
    function automatic t_word mul_mod(t_word a, t_word b);
        logic [127:0] prod;
        t_word        low;
        t_word        high;
        prod = {64'd0, a} * {64'd0, b};
        low  = prod[63:0] & MODULUS;
        high = t_word'(prod >> PRIME_BITS);
        return add_mod(low, high);
    endfunction

    function automatic t_butterfly_res predict_butterfly(
        logic op, gfp2ntt_pkg::t_field a_re, gfp2ntt_pkg::t_field a_im,
        gfp2ntt_pkg::t_field b_re, gfp2ntt_pkg::t_field b_im,
        gfp2ntt_pkg::t_field tw_re, gfp2ntt_pkg::t_field tw_im
    );
        t_word          ar, ai, br, bi, wr, wi;
        t_word          xr, xi, tr, ti;
        t_word          sr, si, dr, di;
        t_butterfly_res res;
        ar = reduce_operand(a_re);
        ai = reduce_operand(a_im);
        br = reduce_operand(b_re);
        bi = reduce_operand(b_im);
        wr = reduce_operand(tw_re);
        wi = reduce_operand(tw_im);
        if (op == gfp2ntt_pkg::OP_FWD) begin
            // Decimation in frequency: the difference is rotated by the twiddle.
            xr = sub_mod(ar, br);
            xi = sub_mod(ai, bi);
            sr = add_mod(ar, br);
            si = add_mod(ai, bi);
            dr = sub_mod(mul_mod(xr, wr), mul_mod(xi, wi));
            di = add_mod(mul_mod(xi, wr), mul_mod(xr, wi));
        end else begin
            // Decimation in time: b is rotated by the conjugate twiddle first.
            tr = add_mod(mul_mod(br, wr), mul_mod(bi, wi));
            ti = sub_mod(mul_mod(bi, wr), mul_mod(br, wi));
            sr = add_mod(ar, tr);
            si = add_mod(ai, ti);
            dr = sub_mod(ar, tr);
            di = sub_mod(ai, ti);
        end
        res.sum_re  = gfp2ntt_pkg::t_field'(sr & FIELD_MASK);
        res.sum_im  = gfp2ntt_pkg::t_field'(si & FIELD_MASK);
        res.diff_re = gfp2ntt_pkg::t_field'(dr & FIELD_MASK);
        res.diff_im = gfp2ntt_pkg::t_field'(di & FIELD_MASK);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH on result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, gfp2ntt_pkg::t_field got,
                               gfp2ntt_pkg::t_field want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h, predicted %h", name, got, want));
        end
    endtask

    // Results are checked before the new transfer is queued, since the
    // pipeline cannot return an item in the cycle it was accepted.
    always @(posedge i_clk) begin
        t_butterfly_res want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (butterfly_q.size() == 0) begin
                    report_mismatch($sformatf("no result pending, got sum=(%h,%h)",
                                              i_sum_re, i_sum_im));
                end else begin
                    want = butterfly_q.pop_front();
                    check_field("sum_re", i_sum_re, want.sum_re);
                    check_field("sum_im", i_sum_im, want.sum_im);
                    check_field("diff_re", i_diff_re, want.diff_re);
                    check_field("diff_im", i_diff_im, want.diff_im);
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                butterfly_q.push_back(predict_butterfly(i_opcode, i_a_re, i_a_im,
                                                        i_b_re, i_b_im,
                                                        i_tw_re, i_tw_im));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= butterfly_q.size();
        o_checked    <= results_seen;
    end

endmodule

// ----- dv/gf_p2_ntt_butterfly_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf_p2_ntt_butterfly_test
// Drives forward and backward butterflies into the block with random gaps on
// the input and random stalls on the output; the checker predicts and compares.
// ----------------------------------------------------------------------------
module gf_p2_ntt_butterfly_test;

    localparam int     PRIME_BITS   = 61;
    localparam int     RANDOM_ITEMS = 800;
    localparam int     STALL_LIMIT  = 1000;
    localparam int     DRAIN_CYCLES = 16;
    localparam gfp2ntt_pkg::t_field P_MOD = (gfp2ntt_pkg::t_field'(1) << PRIME_BITS) - 1;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_opcode    = gfp2ntt_pkg::OP_FWD;
    gfp2ntt_pkg::t_field i_a_re      = '0;
    gfp2ntt_pkg::t_field i_a_im      = '0;
    gfp2ntt_pkg::t_field i_b_re      = '0;
    gfp2ntt_pkg::t_field i_b_im      = '0;
    gfp2ntt_pkg::t_field i_tw_re     = '0;
    gfp2ntt_pkg::t_field i_tw_im     = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    gfp2ntt_pkg::t_field o_sum_re;
    gfp2ntt_pkg::t_field o_sum_im;
    gfp2ntt_pkg::t_field o_diff_re;
    gfp2ntt_pkg::t_field o_diff_im;

    int   fail_count;
    int   pending;
    int   checked;
    int   sent_fwd       = 0;
    int   sent_bwd       = 0;
    int   sent_unreduced = 0;
    int   idle_cycles    = 0;
    int   stall_left     = 0;
    int   rx_gap;
    logic no_idle        = 1'b0;

    gf_p2_ntt_butterfly #(
        .PRIME_BITS (PRIME_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_a_re      (i_a_re),
        .i_a_im      (i_a_im),
        .i_b_re      (i_b_re),
        .i_b_im      (i_b_im),
        .i_tw_re     (i_tw_re),
        .i_tw_im     (i_tw_im),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sum_re    (o_sum_re),
        .o_sum_im    (o_sum_im),
        .o_diff_re   (o_diff_re),
        .o_diff_im   (o_diff_im)
    );

    gf_p2_ntt_butterfly_checker #(
        .PRIME_BITS (PRIME_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_a_re       (i_a_re),
        .i_a_im       (i_a_im),
        .i_b_re       (i_b_re),
        .i_b_im       (i_b_im),
        .i_tw_re      (i_tw_re),
        .i_tw_im      (i_tw_im),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_sum_re     (o_sum_re),
        .i_sum_im     (o_sum_im),
        .i_diff_re    (o_diff_re),
        .i_diff_im    (o_diff_im),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Operand values weighted toward the edges of the field, including p itself.
    function automatic gfp2ntt_pkg::t_field rand_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)  return '0;
        if (r < 12) return P_MOD - 1;
        if (r < 15) return P_MOD;
        if (r < 20) return gfp2ntt_pkg::t_field'($urandom_range(0, 15));
        if (r < 25) return P_MOD - 1 - gfp2ntt_pkg::t_field'($urandom_range(0, 15));
        return gfp2ntt_pkg::t_field'({$urandom, $urandom});
    endfunction

    // Output stalls: a random stall length is drawn whenever the last one ends.
    always @(posedge i_clk) begin
        if (no_idle) begin
            stall_left  <= 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            rx_gap = pick_gap();
            stall_left  <= (rx_gap > 0) ? rx_gap - 1 : 0;
            i_out_ready <= (rx_gap == 0);
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results pending",
                     idle_cycles, pending);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one butterfly, holding it until the transfer happens.
    task automatic send_butterfly(input logic op,
                                  input gfp2ntt_pkg::t_field ar,
                                  input gfp2ntt_pkg::t_field ai,
                                  input gfp2ntt_pkg::t_field br,
                                  input gfp2ntt_pkg::t_field bi,
                                  input gfp2ntt_pkg::t_field wr,
                                  input gfp2ntt_pkg::t_field wi);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_a_re     <= ar;
        i_a_im     <= ai;
        i_b_re     <= br;
        i_b_im     <= bi;
        i_tw_re    <= wr;
        i_tw_im    <= wi;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == gfp2ntt_pkg::OP_FWD) sent_fwd++;
        else sent_bwd++;
        if (ar >= P_MOD || ai >= P_MOD || br >= P_MOD || bi >= P_MOD ||
            wr >= P_MOD || wi >= P_MOD) begin
            sent_unreduced++;
        end
    endtask

    // Random butterfly: equal operands and unit twiddles appear now and then.
    task automatic send_random_butterfly();
        logic                op;
        gfp2ntt_pkg::t_field ar, ai, br, bi, wr, wi;
        op = $urandom_range(0, 1) ? gfp2ntt_pkg::OP_BWD : gfp2ntt_pkg::OP_FWD;
        ar = rand_operand();
        ai = rand_operand();
        br = rand_operand();
        bi = rand_operand();
        wr = rand_operand();
        wi = rand_operand();
        if ($urandom_range(0, 9) == 0) begin
            br = ar;
            bi = ai;
        end
        case ($urandom_range(0, 9))
            0: begin
                wr = 1;
                wi = 0;
            end
            1: begin
                wr = 0;
                wi = 1;
            end
            default: ;
        endcase
        send_butterfly(op, ar, ai, br, bi, wr, wi);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zeros, the largest reduced value, p itself, wrap of the
        // subtract, unit and imaginary twiddles, equal operands, bit patterns.
        send_butterfly(gfp2ntt_pkg::OP_FWD, 0, 0, 0, 0, 0, 0);
        send_butterfly(gfp2ntt_pkg::OP_BWD, 0, 0, 0, 0, 0, 0);
        send_butterfly(gfp2ntt_pkg::OP_FWD, P_MOD - 1, P_MOD - 1, P_MOD - 1, P_MOD - 1,
                       P_MOD - 1, P_MOD - 1);
        send_butterfly(gfp2ntt_pkg::OP_BWD, P_MOD - 1, P_MOD - 1, P_MOD - 1, P_MOD - 1,
                       P_MOD - 1, P_MOD - 1);
        send_butterfly(gfp2ntt_pkg::OP_FWD, 0, 0, P_MOD - 1, P_MOD - 1, 1, 0);
        send_butterfly(gfp2ntt_pkg::OP_BWD, 0, 0, P_MOD - 1, P_MOD - 1, 1, 0);
        send_butterfly(gfp2ntt_pkg::OP_FWD, 61'h123456789ABCDEF, 61'h0FEDCBA98765432,
                       61'h123456789ABCDEF, 61'h0FEDCBA98765432,
                       61'h0AB54A98CEB1F0D, 61'h1234567890ABCDE);
        send_butterfly(gfp2ntt_pkg::OP_FWD, 5, P_MOD - 7, 61'h0CAFE, 61'h1ABCDEF012345,
                       0, 1);
        send_butterfly(gfp2ntt_pkg::OP_BWD, 5, P_MOD - 7, 61'h0CAFE, 61'h1ABCDEF012345,
                       0, 1);
        send_butterfly(gfp2ntt_pkg::OP_FWD, P_MOD, P_MOD, P_MOD, P_MOD, P_MOD, P_MOD);
        send_butterfly(gfp2ntt_pkg::OP_BWD, P_MOD, P_MOD, P_MOD, P_MOD, P_MOD, P_MOD);
        send_butterfly(gfp2ntt_pkg::OP_FWD, P_MOD, 1, 0, P_MOD, P_MOD - 1, P_MOD);
        send_butterfly(gfp2ntt_pkg::OP_BWD, 1, P_MOD, P_MOD, 0, P_MOD, P_MOD - 1);
        send_butterfly(gfp2ntt_pkg::OP_BWD, 0, 0, P_MOD - 1, P_MOD - 1,
                       P_MOD - 1, P_MOD - 1);
        send_butterfly(gfp2ntt_pkg::OP_FWD, 1, 1, P_MOD - 1, P_MOD - 1,
                       P_MOD - 1, P_MOD - 1);
        send_butterfly(gfp2ntt_pkg::OP_BWD, P_MOD - 1, 0, 1, 1, 1, 0);
        send_butterfly(gfp2ntt_pkg::OP_FWD, 61'h0AAAAAAAAAAAAAAA, 61'h1555555555555555,
                       61'h1555555555555555, 61'h0AAAAAAAAAAAAAAA,
                       61'h0AAAAAAAAAAAAAAA, 61'h1555555555555555);
        send_butterfly(gfp2ntt_pkg::OP_BWD, 61'h1555555555555555, 61'h0AAAAAAAAAAAAAAA,
                       61'h0AAAAAAAAAAAAAAA, 61'h1555555555555555,
                       61'h1555555555555555, 61'h0AAAAAAAAAAAAAAA);

        // Random phases; every fourth one runs both sides without idling.
        for (int phase = 0; phase < RANDOM_ITEMS / 100; phase++) begin
            no_idle = (phase % 4 == 2);
            for (int n = 0; n < 100; n++) begin
                send_random_butterfly();
            end
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        // Drain the pipeline, then give stray results a chance to show up.
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d butterflies: %0d forward, %0d backward, %0d with an operand at p.",
                 sent_fwd + sent_bwd, sent_fwd, sent_bwd, sent_unreduced);
        $display("Compared %0d results field by field; %0d still outstanding.",
                 checked, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
